// ===== hw/rtl/sfr_pkg.sv =====
package sfr_pkg;

    // Fixed field widths
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 64;
    localparam int LEN_W     = 4;
    localparam int CFG_IDX_W = 4;
    localparam int REP_IDX_W = 3;

    // Default sizes handed to the top level
    localparam int DEF_MAX_PATTERN     = 8;
    localparam int DEF_MAX_REPLACEMENT = 8;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_BYTES = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_REP_BYTES = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_REP_LEN   = CFG_IDX_W'(3);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SHIFT,
        ST_REPL,
        ST_MARK
    } sfr_state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;    // take the input byte into the pending buffer
        logic clear_buf;  // full match: drop pending bytes
        logic rep_rst;    // restart the replacement byte index
        logic emit_shift; // emit oldest pending byte and shift the buffer
        logic emit_repl;  // emit the current replacement byte
        logic emit_mark;  // emit the end marker with no data
    } sfr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_match;   // buffer holds the whole pattern
        logic need_shift; // oldest byte must leave (mismatch or flush)
        logic last;       // the byte being processed ends the text
        logic rep_zero;   // replacement is empty
        logic rep_final;  // current replacement byte is the final one
        logic out_free;   // output register can load this cycle
    } sfr_sts_t;

endpackage

// ===== hw/rtl/sfr_ctrl.sv =====
module sfr_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  sfr_pkg::sfr_sts_t sts,
    output sfr_pkg::sfr_cmd_t cmd
);
    import sfr_pkg::*;

    sfr_state_t state_reg;
    sfr_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (sts.is_match) begin
                    if (!sts.rep_zero) begin
                        state_next = ST_REPL;
                    end else if (sts.last) begin
                        state_next = ST_MARK;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else if (sts.need_shift) begin
                    state_next = ST_SHIFT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SHIFT: begin
                if (!sts.need_shift) begin
                    state_next = ST_IDLE;
                end
            end
            ST_REPL: begin
                if (sts.out_free && sts.rep_final) begin
                    state_next = ST_IDLE;
                end
            end
            ST_MARK: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands; no transaction is taken while reset is held
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = aresetn;
                cmd.capture = s_tvalid && aresetn;
            end
            ST_EVAL: begin
                cmd.clear_buf = sts.is_match;
                cmd.rep_rst   = sts.is_match;
            end
            ST_SHIFT: begin
                cmd.emit_shift = sts.need_shift && sts.out_free;
            end
            ST_REPL: begin
                cmd.emit_repl = sts.out_free;
            end
            ST_MARK: begin
                cmd.emit_mark = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/sfr_datapath.sv =====
module sfr_datapath #(
    parameter int MAX_PATTERN     = sfr_pkg::DEF_MAX_PATTERN,
    parameter int MAX_REPLACEMENT = sfr_pkg::DEF_MAX_REPLACEMENT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input byte
    input  logic [sfr_pkg::BYTE_W-1:0]         in_byte,
    input  logic                               in_last,
    // configuration writes
    input  logic                               cfg_valid,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sfr_pkg::WORD_W-1:0]         cfg_data,
    // result register
    output logic [sfr_pkg::BYTE_W-1:0]         out_byte,
    output logic                               out_has_byte,
    output logic                               out_end,
    output logic                               out_valid,
    input  logic                               out_ready,
    // controller link
    input  sfr_pkg::sfr_cmd_t                  cmd,
    output sfr_pkg::sfr_sts_t                  sts
);
    import sfr_pkg::*;

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);

    // Configuration registers
    logic [WORD_W-1:0] pat_bytes_reg, pat_bytes_next;
    logic [LEN_W-1:0]  pat_len_reg,   pat_len_next;
    logic [WORD_W-1:0] rep_bytes_reg, rep_bytes_next;
    logic [LEN_W-1:0]  rep_len_reg,   rep_len_next;

    // Pending buffer, oldest byte at entry 0
    logic [BYTE_W-1:0] buf_reg  [MAX_PATTERN];
    logic [BYTE_W-1:0] buf_next [MAX_PATTERN];
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic              last_reg, last_next;
    logic [REP_IDX_W-1:0] rep_idx_reg, rep_idx_next;

    // Output register
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_has_reg,  out_has_next;
    logic              out_end_reg,  out_end_next;
    logic              out_valid_reg, out_valid_next;

    logic [LEN_W-1:0]  pat_eff;
    logic [LEN_W-1:0]  rep_eff;
    logic [LEN_W-1:0]  cnt_ext;
    logic [MAX_PATTERN-1:0] byte_ok;
    logic              prefix;
    logic              out_free;

    // Effective lengths: pattern clamped to 1..MAX, replacement to MAX
    always_comb begin
        if (pat_len_reg == '0) begin
            pat_eff = LEN_W'(1);
        end else if (pat_len_reg > LEN_W'(MAX_PATTERN)) begin
            pat_eff = LEN_W'(MAX_PATTERN);
        end else begin
            pat_eff = pat_len_reg;
        end
        if (rep_len_reg > LEN_W'(MAX_REPLACEMENT)) begin
            rep_eff = LEN_W'(MAX_REPLACEMENT);
        end else begin
            rep_eff = rep_len_reg;
        end
    end

    // Prefix check: every held byte equals the pattern byte at its place
    assign cnt_ext = LEN_W'(cnt_reg);
    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            byte_ok[i] = (LEN_W'(i) >= cnt_ext) ||
                         (buf_reg[i] == pat_bytes_reg[i*BYTE_W +: BYTE_W]);
        end
    end
    assign prefix   = &byte_ok;
    assign out_free = !out_valid_reg || out_ready;

    // Status
    always_comb begin
        sts.is_match   = (cnt_ext == pat_eff) && prefix;
        sts.need_shift = (cnt_reg != '0) && (last_reg || !prefix);
        sts.last       = last_reg;
        sts.rep_zero   = (rep_eff == '0);
        sts.rep_final  = ((LEN_W'(rep_idx_reg) + LEN_W'(1)) == rep_eff);
        sts.out_free   = out_free;
    end

    // Configuration writes; a new pattern discards pending bytes
    always_comb begin
        pat_bytes_next = pat_bytes_reg;
        pat_len_next   = pat_len_reg;
        rep_bytes_next = rep_bytes_reg;
        rep_len_next   = rep_len_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_PAT_BYTES: pat_bytes_next = cfg_data;
                CFG_PAT_LEN:   pat_len_next   = cfg_data[LEN_W-1:0];
                CFG_REP_BYTES: rep_bytes_next = cfg_data;
                CFG_REP_LEN:   rep_len_next   = cfg_data[LEN_W-1:0];
                default:       pat_len_next   = pat_len_reg;
            endcase
        end
    end

    // Pending buffer, count, end flag and replacement index
    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            buf_next[i] = buf_reg[i];
        end
        cnt_next     = cnt_reg;
        last_next    = last_reg;
        rep_idx_next = rep_idx_reg;

        if (cmd.capture) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                if (cnt_reg == CNT_W'(i)) begin
                    buf_next[i] = in_byte;
                end
            end
            cnt_next  = cnt_reg + CNT_W'(1);
            last_next = in_last;
        end

        if (cmd.emit_shift) begin
            for (int i = 0; i < MAX_PATTERN - 1; i++) begin
                buf_next[i] = buf_reg[i + 1];
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end

        if (cmd.clear_buf) begin
            cnt_next = '0;
        end
        if (cmd.rep_rst) begin
            rep_idx_next = '0;
        end else if (cmd.emit_repl) begin
            rep_idx_next = rep_idx_reg + REP_IDX_W'(1);
        end

        if (cfg_valid && (cfg_index == CFG_PAT_BYTES || cfg_index == CFG_PAT_LEN)) begin
            cnt_next = '0;
        end
    end

    // Output register: loads one result, holds it until taken
    always_comb begin
        out_byte_next  = out_byte_reg;
        out_has_next   = out_has_reg;
        out_end_next   = out_end_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.emit_shift) begin
            out_byte_next  = buf_reg[0];
            out_has_next   = 1'b1;
            out_end_next   = last_reg && (cnt_reg == CNT_W'(1));
            out_valid_next = 1'b1;
        end else if (cmd.emit_repl) begin
            out_byte_next  = rep_bytes_reg[{rep_idx_reg, 3'b000} +: BYTE_W];
            out_has_next   = 1'b1;
            out_end_next   = last_reg && sts.rep_final;
            out_valid_next = 1'b1;
        end else if (cmd.emit_mark) begin
            out_byte_next  = '0;
            out_has_next   = 1'b0;
            out_end_next   = 1'b1;
            out_valid_next = 1'b1;
        end
    end

    // Control state and configuration with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_bytes_reg <= '0;
            pat_len_reg   <= LEN_W'(1);
            rep_bytes_reg <= '0;
            rep_len_reg   <= '0;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            rep_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pat_bytes_reg <= pat_bytes_next;
            pat_len_reg   <= pat_len_next;
            rep_bytes_reg <= rep_bytes_next;
            rep_len_reg   <= rep_len_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            rep_idx_reg   <= rep_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            buf_reg[i] <= buf_next[i];
        end
        out_byte_reg <= out_byte_next;
        out_has_reg  <= out_has_next;
        out_end_reg  <= out_end_next;
    end

    assign out_byte     = out_byte_reg;
    assign out_has_byte = out_has_reg;
    assign out_end      = out_end_reg;
    assign out_valid    = out_valid_reg;

endmodule

// ===== hw/rtl/stream_find_and_replace_core.sv =====
// Each accepted byte is checked in the evaluate state; its results then go through the
// output register, one result a cycle unless the receiver stalls. After a run of
// shifted-out bytes the buffer is rechecked; a new byte is taken only in idle.
// Reset (aresetn low, synchronous): pattern 0 of length 1, empty replacement,
// pending buffer empty, no result held.
module stream_find_and_replace_core #(
    parameter int MAX_PATTERN     = sfr_pkg::DEF_MAX_PATTERN,
    parameter int MAX_REPLACEMENT = sfr_pkg::DEF_MAX_REPLACEMENT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input text
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sfr_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] text_byte
    input  logic                          s_tlast,   // end_of_text
    // results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sfr_pkg::BYTE_W-1:0]    m_tdata,   // [7:0] out_byte
    output logic                          m_tuser,   // has_byte
    output logic                          m_tlast,   // end_of_output
    // configuration
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfr_pkg::WORD_W-1:0]    cfg_data
);
    import sfr_pkg::*;

    sfr_cmd_t cmd;
    sfr_sts_t sts;

    // Registers are writable whenever out of reset
    assign cfg_ready = aresetn;

    // Sequencer
    sfr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Buffer, compare and output register
    sfr_datapath #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_byte      (s_tdata),
        .in_last      (s_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_byte     (m_tdata),
        .out_has_byte (m_tuser),
        .out_end      (m_tlast),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import sfr_pkg::*;

    localparam int IDLE_LIMIT    = 4000;  // cycles without any transaction
    localparam int SETTLE_CYCLES = 12;    // quiet time before a register write
    localparam int LONG_HOLD     = 200;   // receiver hold-off, in cycles
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 34;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              has_byte;
        logic              eot;
    } out_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
    } text_item_t;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_EVERY_FOURTH, RX_MOSTLY} rx_mode_t;

    // Shadow of the replace engine: registers, pending bytes, awaited output
    class replace_scoreboard;
        logic [WORD_W-1:0] pat_word;
        logic [LEN_W-1:0]  pat_len_reg;
        logic [WORD_W-1:0] rep_word;
        logic [LEN_W-1:0]  rep_len_reg;
        logic [BYTE_W-1:0] held [8];
        int                held_cnt;
        int                step_n;
        out_item_t         awaited [$];
        int errors, n_bytes, n_texts, n_hits, n_markers, n_checked, n_writes;

        function new();
            pat_word    = '0;
            pat_len_reg = LEN_W'(1);
            rep_word    = '0;
            rep_len_reg = '0;
            held_cnt    = 0;
            foreach (held[i]) held[i] = '0;
            errors = 0; n_bytes = 0; n_texts = 0; n_hits = 0;
            n_markers = 0; n_checked = 0; n_writes = 0;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
            n_writes++;
            case (idx)
                CFG_PAT_BYTES: begin
                    pat_word = val;
                    held_cnt = 0;
                end
                CFG_PAT_LEN: begin
                    pat_len_reg = val[LEN_W-1:0];
                    held_cnt    = 0;
                end
                CFG_REP_BYTES: rep_word = val;
                CFG_REP_LEN:   rep_len_reg = val[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        // at most eight results leave per input byte
        function void push(logic [BYTE_W-1:0] b, logic has, logic eot);
            out_item_t entry;
            if (step_n < 8) begin
                entry = '{b, has, eot};
                awaited.insert(awaited.size(), entry);
                step_n++;
            end
        endfunction

        function bit held_is_prefix();
            for (int i = 0; i < held_cnt && i < 8; i++)
                if (held[i] != pat_word[8*i +: 8]) return 1'b0;
            return 1'b1;
        endfunction

        function void shift_oldest();
            push(held[0], 1'b1, 1'b0);
            for (int i = 1; i < held_cnt && i < 8; i++) held[i-1] = held[i];
            held_cnt--;
        endfunction

        function void note_text_byte(logic [BYTE_W-1:0] b, logic last);
            int        plen;
            int        rlen;
            n_bytes++;
            step_n = 0;
            // zero length acts as one, anything above eight as eight
            plen = (pat_len_reg == 0) ? 1 : ((pat_len_reg > 8) ? 8 : int'(pat_len_reg));
            if (held_cnt >= plen) held_cnt = 0;
            held[held_cnt[2:0]] = b;
            held_cnt++;
            if (held_cnt == plen && held_is_prefix()) begin
                rlen = (rep_len_reg > 8) ? 8 : int'(rep_len_reg);
                for (int i = 0; i < rlen; i++) push(rep_word[8*i +: 8], 1'b1, 1'b0);
                held_cnt = 0;
                n_hits++;
            end else begin
                while (held_cnt > 0 && !held_is_prefix()) shift_oldest();
            end
            if (last) begin
                n_texts++;
                while (held_cnt > 0) shift_oldest();
                if (step_n == 0) begin
                    push('0, 1'b0, 1'b1);
                    n_markers++;
                end else begin
                    awaited[awaited.size() - 1].eot = 1'b1;
                end
            end
        endfunction

        function void check_output(logic [BYTE_W-1:0] data, logic has, logic eot);
            out_item_t exp_item;
            if (awaited.size() == 0) begin
                $error("unexpected result: out_byte %02h has_byte %0b end_of_output %0b",
                       data, has, eot);
                errors++;
                return;
            end
            exp_item = awaited.pop_front();
            n_checked++;
            if (data !== exp_item.data) begin
                $error("out_byte: expected %02h, got %02h", exp_item.data, data);
                errors++;
            end
            if (has !== exp_item.has_byte) begin
                $error("has_byte: expected %0b, got %0b", exp_item.has_byte, has);
                errors++;
            end
            if (eot !== exp_item.eot) begin
                $error("end_of_output: expected %0b, got %0b", exp_item.eot, eot);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [BYTE_W-1:0]    m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data  = '0;

    replace_scoreboard sb;
    text_item_t        text_q [$];
    int                text_left = 0;
    int                burst_left = 0;
    bit                no_gap = 1'b0;
    int                hold_reqs = 0;
    logic [WORD_W-1:0] cur_pat = '0;
    int                gen_len = 1;
    int                idle_cyc = 0;

    stream_find_and_replace_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Transaction monitor: all three channels sampled at the edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.apply_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) sb.note_text_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) sb.check_output(m_tdata, m_tuser, m_tlast);
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (cfg_valid && cfg_ready) || (s_tvalid && s_tready)
                || (m_tvalid && m_tready)) begin
            idle_cyc <= 0;
        end else if (idle_cyc >= IDLE_LIMIT) begin
            $display("FAIL stream_find_and_replace_core");
            $finish;
        end else begin
            idle_cyc <= idle_cyc + 1;
        end
    end

    // Receiver: changing stall pattern, plus long hold-offs on request
    initial begin
        rx_mode_t mode;
        int       span;
        int       hold_left;
        int       served;
        int       cyc;
        mode = RX_ALWAYS;
        span = 0;
        hold_left = 0;
        served = 0;
        cyc = 0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (hold_reqs != served) begin
                served    = hold_reqs;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (span == 0) begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    span = $urandom_range(20, 120);
                end
                span--;
                case (mode)
                    RX_ALWAYS:       m_tready <= 1'b1;
                    RX_COIN:         m_tready <= 1'($urandom_range(0, 1));
                    RX_EVERY_FOURTH: m_tready <= (cyc % 4 == 0);
                    default:         m_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    function automatic void add_byte(logic [BYTE_W-1:0] v);
        text_item_t entry;
        text_left--;
        entry = '{v, text_left == 0};
        text_q.insert(text_q.size(), entry);
    endfunction

    // Texts built mostly from whole patterns, partial patterns and pattern bytes
    function automatic void make_texts(int count, bit leave_open);
        int         r;
        int         cut;
        text_q.delete();
        while (text_q.size() < count) begin
            if (text_left <= 0) text_left = $urandom_range(1, 24);
            r = $urandom_range(0, 9);
            if (r < 4) cut = gen_len;
            else if (r < 6) cut = $urandom_range(0, gen_len - 1);
            else cut = 0;
            for (int k = 0; k < cut && text_left > 0 && text_q.size() < count; k++)
                add_byte(cur_pat[8*k +: 8]);
            if (r >= 4 && text_left > 0 && text_q.size() < count) begin
                if (r < 8) add_byte(cur_pat[8*$urandom_range(0, gen_len - 1) +: 8]);
                else add_byte(BYTE_W'($urandom_range(0, 255)));
            end
        end
        text_q[text_q.size() - 1].last = !leave_open;
        text_left = 0;
    endfunction

    // Offer the queued bytes in bursts with random gaps
    task automatic send_texts();
        int gap;
        foreach (text_q[i]) begin
            if (burst_left == 0) begin
                gap = no_gap ? 0 : $urandom_range(0, 6);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    s_tdata  <= BYTE_W'($urandom_range(0, 255));
                    repeat (gap) @(posedge aclk);
                end
                burst_left = $urandom_range(1, 16);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= text_q[i].value;
            s_tlast  <= text_q[i].last;
            do @(posedge aclk); while (!s_tready);
            burst_left--;
        end
    endtask

    // Wait until every awaited result has arrived and the block has gone quiet
    task automatic drain();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_config(input logic [WORD_W-1:0] pat, input logic [LEN_W-1:0] plen,
                              input logic [WORD_W-1:0] rep, input logic [LEN_W-1:0] rlen,
                              input bit keep_pattern, input bit stray);
        if (!keep_pattern) begin
            write_reg(CFG_PAT_BYTES, pat);
            write_reg(CFG_PAT_LEN, WORD_W'(plen));
            cur_pat = pat;
            gen_len = (plen == 0) ? 1 : ((plen > 8) ? 8 : int'(plen));
        end
        write_reg(CFG_REP_BYTES, rep);
        write_reg(CFG_REP_LEN, WORD_W'(rlen));
        // unused index, must change nothing
        if (stray)
            write_reg(CFG_IDX_W'($urandom_range(int'(CFG_REP_LEN) + 1, 15)),
                      {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [WORD_W-1:0] pat;
        logic [LEN_W-1:0]  plen;
        logic [LEN_W-1:0]  rlen;
        bit                leave_open;
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: single zero byte deleted; lone match at the end gives a marker
        text_q = '{'{8'h00, 1'b0}, '{8'hFF, 1'b0}, '{8'h00, 1'b1}, '{8'h5A, 1'b1}};
        send_texts();
        drain();

        // Zero pattern length acts as one, oversized replacement saturates at eight
        set_config(64'h41, 4'd0, 64'h0123_4567_89AB_CDEF, 4'd15, 1'b0, 1'b1);
        text_q = '{'{8'h41, 1'b1}, '{8'h42, 1'b0}, '{8'h41, 1'b1}};
        send_texts();
        drain();

        // Oversized pattern length saturates; seven-byte prefix then a break flushes eight
        set_config(64'h00FF_00FF_0102_0304, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0,
                   1'b0, 1'b0);
        text_q.delete();
        for (int k = 0; k < 7; k++) text_q.insert(text_q.size(), '{cur_pat[8*k +: 8], 1'b0});
        text_q.insert(text_q.size(), '{8'h55, 1'b1});
        text_q.insert(text_q.size(), '{8'h04, 1'b0});
        text_q.insert(text_q.size(), '{8'h03, 1'b0});
        text_q.insert(text_q.size(), '{8'h02, 1'b0});
        send_texts();
        drain();

        // Pattern rewritten with bytes still pending: they vanish without output
        set_config(64'h6261, 4'd2, 64'h0, 4'd0, 1'b0, 1'b0);
        text_q = '{'{8'h61, 1'b0}, '{8'h62, 1'b1}, '{8'h61, 1'b0}, '{8'h61, 1'b0},
                   '{8'h62, 1'b1}};
        send_texts();
        drain();

        // Random phases over a spread of settings
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 5)
                0: plen = 4'd8;
                1: plen = 4'd1;
                default: begin
                    if ($urandom_range(0, 5) == 0)
                        plen = $urandom_range(0, 1) ? 4'd0 : LEN_W'($urandom_range(9, 15));
                    else
                        plen = LEN_W'($urandom_range(1, 8));
                end
            endcase
            case (ph % 4)
                0: rlen = 4'd0;
                1: rlen = 4'd8;
                default: rlen = LEN_W'($urandom_range(0, 15));
            endcase
            if (ph == 2) pat = '1;
            else if (ph == 5) pat = '0;
            else if ($urandom_range(0, 1)) begin
                // two-letter alphabet gives self-overlapping patterns
                for (int k = 0; k < 8; k++) pat[8*k +: 8] = $urandom_range(0, 1) ? 8'h61 : 8'h62;
            end else begin
                pat = {$urandom, $urandom};
            end
            set_config(pat, plen, {$urandom, $urandom}, rlen, (ph % 4 == 3), ph[0]);

            leave_open = (ph % 3 == 1);
            no_gap     = (ph == 7 || ph == 8);
            if (ph == 4) hold_reqs <= hold_reqs + 1;
            if (ph == 6) begin
                // sender waits for the block to empty halfway through
                make_texts(PHASE_ITEMS / 2, 1'b1);
                send_texts();
                drain();
                make_texts(PHASE_ITEMS - PHASE_ITEMS / 2, leave_open);
            end else begin
                make_texts(PHASE_ITEMS, leave_open);
            end
            send_texts();
            drain();
        end

        $display("Checked %0d results from %0d text bytes across %0d register writes",
                 sb.n_checked, sb.n_bytes, sb.n_writes);
        $display("%0d texts closed, %0d pattern hits replaced, %0d bare end markers",
                 sb.n_texts, sb.n_hits, sb.n_markers);
        if (sb.errors == 0) begin
            $display("PASS stream_find_and_replace_core");
        end else begin
            $display("FAIL stream_find_and_replace_core");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_ctrl.sv
hw/rtl/sfr_datapath.sv
hw/rtl/stream_find_and_replace_core.sv
tb/tb.sv
